FILE: design/stress_divergence_stencil_assert.svh
// Assertion macros for the stress divergence stencil checker.
// Depends on nothing; included by the checker file.
`ifndef STRESS_DIVERGENCE_STENCIL_ASSERT_SVH
`define STRESS_DIVERGENCE_STENCIL_ASSERT_SVH
// implication checked every clock, quiet in reset
`define SDS_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
// next-cycle implication
`define SDS_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

FILE: design/sds_pkg.sv
// Package for the stress divergence stencil: lattice sizes, delay-line geometry, site type.
// Depends on nothing.
`default_nettype none
package sds_pkg;
   localparam int SIZE_I = 16;
   localparam int SIZE_J = 16;
   localparam int SIZE_K = 16;
   localparam int ROW_LEN = SIZE_K + 2;
   localparam int PLANE_LEN = (SIZE_J + 2) * ROW_LEN;
   localparam int LINE_DEPTH = 2 * PLANE_LEN + 1;
   localparam int PI_W = $clog2(SIZE_I + 2);
   localparam int PJ_W = $clog2(SIZE_J + 2);
   localparam int PK_W = $clog2(SIZE_K + 2);
   localparam int SITE_W = 1 + 9 * 32;
   localparam int FORCE_W = 36;
   localparam int TAP_CNT = 7;
   localparam int PTR_W = $clog2(LINE_DEPTH);
   // tap order: center, up i, dn i, up j, dn j, up k, dn k
   localparam int TAP_C = 0;
   localparam int TAP_DEPTH [TAP_CNT] = '{
      PLANE_LEN, 0, 2 * PLANE_LEN, PLANE_LEN - ROW_LEN, PLANE_LEN + ROW_LEN,
      PLANE_LEN - 1, PLANE_LEN + 1};

   typedef struct packed {
      logic              fluid;
      logic [8:0][31:0]  s;
   } site_type;
endpackage
`default_nettype wire

FILE: design/sds_ram.sv
// Generic single-write, single-read RAM with registered read.
// Depends on nothing.
`default_nettype none
module sds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

FILE: design/stress_divergence_stencil.sv
// Usage: sites enter on the req_ channel in raster order (k fastest, i slowest), halo
// included, one per cycle when not stalled. Each accepted request with an interior
// centre one plane back yields one rsp_ item: center_fluid, force_x/y/z in half input
// LSB units (zero for a solid centre) and last_site on the final interior site.
// Result path: the result for the site entered PLANE_LEN requests ago is registered by
// the RAM read and then the force register, after its neighbourhood is complete.
// Throughput: one request per cycle unless stalled, set by the single delay-line write
// per request; six taps each read their own RAM copy, the current site is registered.
// Stall: the pipeline advances only while its output slot is free or being taken;
// req_stall follows the rsp_ side so a stalled response holds steady.
// Reset (synchronous, active high) clears position, pointer and valid flags; the RAM
// contents are not cleared and feed a response only once written in the current pass.
`default_nettype none
module stress_divergence_stencil
   import sds_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_site_fluid,
   input  wire logic signed [31:0]         req_s_xx,
   input  wire logic signed [31:0]         req_s_xy,
   input  wire logic signed [31:0]         req_s_xz,
   input  wire logic signed [31:0]         req_s_yx,
   input  wire logic signed [31:0]         req_s_yy,
   input  wire logic signed [31:0]         req_s_yz,
   input  wire logic signed [31:0]         req_s_zx,
   input  wire logic signed [31:0]         req_s_zy,
   input  wire logic signed [31:0]         req_s_zz,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic                            rsp_center_fluid,
   output logic signed [FORCE_W-1:0]       rsp_force_x,
   output logic signed [FORCE_W-1:0]       rsp_force_y,
   output logic signed [FORCE_W-1:0]       rsp_force_z,
   output logic                            rsp_last_site
);
   logic             adv;
   logic             acc;
   logic [PI_W-1:0]  pos_i_ff, pos_i_in;
   logic [PJ_W-1:0]  pos_j_ff, pos_j_in;
   logic [PK_W-1:0]  pos_k_ff, pos_k_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic             emit;
   logic             last;
   logic             s1_valid_ff, s1_last_ff;
   site_type         cur;
   site_type         tap [TAP_CNT];
   logic signed [FORCE_W-1:0] f [3];

   assign adv = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;
   assign acc = req_valid && adv;

   assign cur.fluid = req_site_fluid;
   assign cur.s = {req_s_zz, req_s_zy, req_s_zx, req_s_yz, req_s_yy, req_s_yx,
                   req_s_xz, req_s_xy, req_s_xx};

   assign emit = (32'(pos_i_ff) >= 2) && (32'(pos_j_ff) >= 1) &&
                 (32'(pos_j_ff) <= SIZE_J) && (32'(pos_k_ff) >= 1) &&
                 (32'(pos_k_ff) <= SIZE_K);
   assign last = (32'(pos_i_ff) == SIZE_I + 1) && (32'(pos_j_ff) == SIZE_J) &&
                 (32'(pos_k_ff) == SIZE_K);

   // tap m back from the current write: the current site itself is tap depth 0
   for (genvar t = 0; t < TAP_CNT; t++) begin : g_tap
      if (TAP_DEPTH[t] == 0) begin : g_now
         site_type now_ff;
         always_ff @(posedge clock) begin
            if (acc) begin
               now_ff <= cur;
            end
         end
         assign tap[t] = now_ff;
      end else begin : g_mem
         logic [PTR_W:0]   rd_sum;
         logic [PTR_W-1:0] rd_addr;
         assign rd_sum = {1'b0, wr_ptr_ff} + (PTR_W+1)'(LINE_DEPTH - TAP_DEPTH[t]);
         assign rd_addr = (rd_sum >= (PTR_W+1)'(LINE_DEPTH)) ?
                          PTR_W'(rd_sum - (PTR_W+1)'(LINE_DEPTH)) : rd_sum[PTR_W-1:0];
         sds_ram #(.WIDTH(SITE_W), .DEPTH(LINE_DEPTH)) u_ram (
            .clock   (clock),
            .wr_en   (acc),
            .wr_addr (wr_ptr_ff),
            .wr_data (cur),
            .rd_en   (acc),
            .rd_addr (rd_addr),
            .rd_data (tap[t])
         );
      end
   end

   always_comb begin
      pos_i_in = pos_i_ff;
      pos_j_in = pos_j_ff;
      pos_k_in = pos_k_ff;
      if (32'(pos_k_ff) >= SIZE_K + 1) begin
         pos_k_in = '0;
         if (32'(pos_j_ff) >= SIZE_J + 1) begin
            pos_j_in = '0;
            if (32'(pos_i_ff) >= SIZE_I + 1) begin
               pos_i_in = '0;
            end else begin
               pos_i_in = pos_i_ff + 1'b1;
            end
         end else begin
            pos_j_in = pos_j_ff + 1'b1;
         end
      end else begin
         pos_k_in = pos_k_ff + 1'b1;
      end
      if (32'(wr_ptr_ff) == LINE_DEPTH - 1) begin
         wr_ptr_in = '0;
      end else begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
   end

   always_comb begin
      logic signed [FORCE_W-1:0] p0, hi, lo;
      for (int a = 0; a < 3; a++) begin
         f[a] = '0;
         for (int b = 0; b < 3; b++) begin
            p0 = FORCE_W'($signed(tap[TAP_C].s[3*a+b]));
            hi = tap[1+2*b].fluid ? p0 + FORCE_W'($signed(tap[1+2*b].s[3*a+b]))
                                  : p0 + p0;
            lo = tap[2+2*b].fluid ? p0 + FORCE_W'($signed(tap[2+2*b].s[3*a+b]))
                                  : p0 + p0;
            f[a] = f[a] + lo - hi;
         end
         if (!tap[TAP_C].fluid) begin
            f[a] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_i_ff    <= '0;
         pos_j_ff    <= '0;
         pos_k_ff    <= '0;
         wr_ptr_ff   <= '0;
         s1_valid_ff <= 1'b0;
         rsp_valid   <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= acc && emit;
         rsp_valid   <= s1_valid_ff;
         if (acc) begin
            pos_i_ff  <= pos_i_in;
            pos_j_ff  <= pos_j_in;
            pos_k_ff  <= pos_k_in;
            wr_ptr_ff <= wr_ptr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_last_ff       <= last;
         rsp_last_site    <= s1_last_ff;
         rsp_center_fluid <= tap[TAP_C].fluid;
         rsp_force_x      <= f[0];
         rsp_force_y      <= f[1];
         rsp_force_z      <= f[2];
      end
   end
endmodule
`default_nettype wire

FILE: design/sds_checker.sv
// Port-level checker for the stress divergence stencil, bound to the top level.
// Depends on stress_divergence_stencil_assert.svh.
`default_nettype none
`include "stress_divergence_stencil_assert.svh"
module sds_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_center_fluid,
   input wire logic [35:0] rsp_force_x,
   input wire logic [35:0] rsp_force_y,
   input wire logic [35:0] rsp_force_z
);
   logic force_zero;
   logic rsp_held;

   assign force_zero = (rsp_force_x == '0) && (rsp_force_y == '0) && (rsp_force_z == '0);
   assign rsp_held = rsp_valid && rsp_stall;

   `SDS_ASSERT_IMP(a_solid_zero, clock, reset, rsp_valid && !rsp_center_fluid, force_zero)
   `SDS_ASSERT_IMP(a_stall_follows, clock, reset, rsp_held, req_stall)
   `SDS_ASSERT_IMP(a_free_no_stall, clock, reset, !rsp_valid, !req_stall)
   `SDS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_force_x))
endmodule

bind stress_divergence_stencil sds_checker u_sds_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_center_fluid (rsp_center_fluid),
   .rsp_force_x      (rsp_force_x),
   .rsp_force_y      (rsp_force_y),
   .rsp_force_z      (rsp_force_z)
);
`default_nettype wire

FILE: sim/tb_stress_divergence_stencil.sv
// Self-checking testbench for stress_divergence_stencil: streams halo planes with
// random stress tensors and fluid flags, predicts each interior force and checks it.
// Depends on sds_pkg and the stress_divergence_stencil RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_stress_divergence_stencil;
   import sds_pkg::*;

   localparam int SITE_COUNT = 1800;
   localparam int HOLD_AT = 900;
   localparam int DRAIN_AT = 1400;

   typedef struct {
      logic        fluid;
      logic [35:0] fx;
      logic [35:0] fy;
      logic [35:0] fz;
      logic        last;
   } force_type;

   class force_board;
      site_type  hist [LINE_DEPTH];
      force_type pending [$];
      int        wp, pi, pj, pk;
      int        errors, checked, solid_seen, last_seen;

      function new();
         wp = 0; pi = 0; pj = 0; pk = 0;
         errors = 0; checked = 0; solid_seen = 0; last_seen = 0;
      endfunction

      function site_type back(int m);
         return hist[(wp + LINE_DEPTH - m) % LINE_DEPTH];
      endfunction

      function void note_site(site_type st);
         int        stride [3];
         site_type  c, up, dn;
         longint    f [3];
         longint    p0, hi, lo;
         force_type e;
         stride = '{PLANE_LEN, ROW_LEN, 1};
         hist[wp] = st;
         if (pi >= 2 && pj >= 1 && pj <= SIZE_J && pk >= 1 && pk <= SIZE_K) begin
            c = back(PLANE_LEN);
            f = '{0, 0, 0};
            if (c.fluid) begin
               for (int b = 0; b < 3; b++) begin
                  up = back(PLANE_LEN - stride[b]);
                  dn = back(PLANE_LEN + stride[b]);
                  for (int a = 0; a < 3; a++) begin
                     p0 = longint'(signed'(c.s[3*a+b]));
                     hi = up.fluid ? p0 + longint'(signed'(up.s[3*a+b])) : 2 * p0;
                     lo = dn.fluid ? p0 + longint'(signed'(dn.s[3*a+b])) : 2 * p0;
                     f[a] += lo - hi;
                  end
               end
            end
            e.fluid = c.fluid;
            e.fx = f[0][35:0];
            e.fy = f[1][35:0];
            e.fz = f[2][35:0];
            e.last = (pi == SIZE_I + 1) && (pj == SIZE_J) && (pk == SIZE_K);
            pending.push_back(e);
         end
         wp = (wp + 1) % LINE_DEPTH;
         if (pk >= SIZE_K + 1) begin
            pk = 0;
            if (pj >= SIZE_J + 1) begin
               pj = 0;
               pi = (pi >= SIZE_I + 1) ? 0 : pi + 1;
            end else begin
               pj++;
            end
         end else begin
            pk++;
         end
      endfunction

      task report(string what, logic [35:0] got, logic [35:0] want);
         errors++;
         $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want, checked);
      endtask

      task check_force(force_type g);
         force_type e;
         if (pending.size() == 0) begin
            report("unexpected result", 0, 0);
            return;
         end
         e = pending.pop_front();
         if (g.fluid !== e.fluid) report("center_fluid", g.fluid, e.fluid);
         if (g.fx !== e.fx) report("force_x", g.fx, e.fx);
         if (g.fy !== e.fy) report("force_y", g.fy, e.fy);
         if (g.fz !== e.fz) report("force_z", g.fz, e.fz);
         if (g.last !== e.last) report("last_site", g.last, e.last);
         if (!e.fluid) solid_seen++;
         if (e.last) last_seen++;
         checked++;
      endtask
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic               req_site_fluid = 0;
   logic signed [31:0] req_s_xx = 0, req_s_xy = 0, req_s_xz = 0;
   logic signed [31:0] req_s_yx = 0, req_s_yy = 0, req_s_yz = 0;
   logic signed [31:0] req_s_zx = 0, req_s_zy = 0, req_s_zz = 0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic               rsp_center_fluid;
   logic signed [FORCE_W-1:0] rsp_force_x, rsp_force_y, rsp_force_z;
   logic               rsp_last_site;

   force_board board = new();
   bit                 hold_rsp = 0;
   bit                 idle_mode = 0;

   stress_divergence_stencil dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   function logic [31:0] pick_stress(int n, int f);
      logic [31:0] ext [5];
      ext = '{32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h0, 32'h1};
      if (n < 25) return ext[(n + f) % 5];
      case ($urandom_range(0, 9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'h0;
         3: return 32'hffffffff;
         4: return 32'($signed($urandom_range(0, 200)) - 100);
         default: return $urandom;
      endcase
   endfunction

   task send_site(int n);
      site_type st;
      int gap;
      st.fluid = (n < 25) ? n[0] : ($urandom_range(0, 4) != 0);
      for (int f = 0; f < 9; f++) st.s[f] = pick_stress(n, f);
      gap = idle_mode ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_site_fluid <= st.fluid;
      req_s_xx <= st.s[0]; req_s_xy <= st.s[1]; req_s_xz <= st.s[2];
      req_s_yx <= st.s[3]; req_s_yy <= st.s[4]; req_s_yz <= st.s[5];
      req_s_zx <= st.s[6]; req_s_zy <= st.s[7]; req_s_zz <= st.s[8];
      // stall is settled at the falling edge for the next rising edge
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      board.note_site(st);
   endtask

   initial begin
      force_type g;
      int n;
      wait (!reset);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end else begin
            n = idle_mode ? $urandom_range(0, 11) : 0;
            if (n > 0) begin
               rsp_stall <= 1;
               repeat (n) @(posedge clock);
            end
         end
         rsp_stall <= 0;
         do @(negedge clock); while (!rsp_valid);
         g.fluid = rsp_center_fluid;
         g.fx = rsp_force_x;
         g.fy = rsp_force_y;
         g.fz = rsp_force_z;
         g.last = rsp_last_site;
         @(posedge clock);
         board.check_force(g);
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int n = 0; n < SITE_COUNT; n++) begin
         if (n % 500 == 0) idle_mode = $urandom_range(0, 2) != 0;
         if (n == HOLD_AT) hold_rsp = 1;
         if (n == DRAIN_AT) begin
            req_valid <= 0;
            while (board.pending.size() != 0) @(posedge clock);
         end
         send_site(n);
      end
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Streamed %0d sites into the leading planes of the lattice, checked %0d forces,",
               SITE_COUNT, board.checked);
      $display("%0d of them solid centers, %0d end-of-lattice flags.",
               board.solid_seen, board.last_seen);
      if (board.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end
endmodule
`default_nettype wire
